// ===== sv/tpbfs_pkg.sv =====
// shared constants, codes and types of the two-pool buffer free stack
package tpbfs_pkg;

    localparam int SMALL_COUNT_DEF = 16;
    localparam int LARGE_COUNT_DEF = 8;
    localparam int SMALL_BYTES_DEF = 32;
    localparam int LARGE_BYTES_DEF = 192;

    localparam int ADDR_W    = 16;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int HIT_W     = 2;
    localparam int SFREE_W   = 5;
    localparam int LFREE_W   = 4;
    localparam int CFG_IDX_W = 1;
    localparam int CMD_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ADDR_W-1:0] SMALL_BASE_RST = 16'd4096;
    localparam logic [ADDR_W-1:0] LARGE_BASE_RST = 16'd8192;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LARGE_BASE = 1'd1;

    // request opcodes
    localparam logic [OP_W-1:0] OP_ALLOC_SMALL = 2'd0;
    localparam logic [OP_W-1:0] OP_ALLOC_LARGE = 2'd1;
    localparam logic [OP_W-1:0] OP_FREE        = 2'd2;
    localparam logic [OP_W-1:0] OP_REBUILD     = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // pool hit codes
    localparam logic [HIT_W-1:0] HIT_NONE  = 2'd0;
    localparam logic [HIT_W-1:0] HIT_SMALL = 2'd1;
    localparam logic [HIT_W-1:0] HIT_LARGE = 2'd2;

    // classified command kinds
    localparam logic [CMD_W-1:0] CMD_ALLOC_S = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ALLOC_L = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FREE_S  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FREE_L  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INVALID = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REBUILD = 3'd5;

    typedef struct packed {
        logic [CMD_W-1:0]  kind;
        logic [ADDR_W-1:0] address;
    } cmd_t;

    // index width for an array of n entries, at least one bit
    function automatic int idx_w(input int n);
        int w;
        begin
            w = (n > 1) ? $clog2(n) : 1;
            return w;
        end
    endfunction

endpackage

// ===== sv/tpbfs_if.sv =====
// request and response channel interfaces

interface tpbfs_req_if;
    logic                          valid;
    logic                          ready;
    logic [tpbfs_pkg::OP_W-1:0]    opcode;
    logic [tpbfs_pkg::ADDR_W-1:0]  address;

    modport source (output valid, output opcode, output address, input ready);
    modport sink (input valid, input opcode, input address, output ready);
endinterface

interface tpbfs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [tpbfs_pkg::ADDR_W-1:0]    buf_address;
    logic [tpbfs_pkg::STATUS_W-1:0]  status;
    logic [tpbfs_pkg::HIT_W-1:0]     pool_hit;
    logic [tpbfs_pkg::SFREE_W-1:0]   small_free;
    logic [tpbfs_pkg::LFREE_W-1:0]   large_free;
    logic [tpbfs_pkg::SFREE_W-1:0]   small_low_water;
    logic [tpbfs_pkg::LFREE_W-1:0]   large_low_water;

    modport source (output valid, output buf_address, output status, output pool_hit,
                    output small_free, output large_free, output small_low_water,
                    output large_low_water, input ready);
    modport sink (input valid, input buf_address, input status, input pool_hit,
                  input small_free, input large_free, input small_low_water,
                  input large_low_water, output ready);
endinterface

// ===== sv/tpbfs_ram.sv =====
// generic single-write, single-read ram with registered read data
module tpbfs_ram #(
    parameter int WIDTH = tpbfs_pkg::ADDR_W,
    parameter int DEPTH = tpbfs_pkg::SMALL_COUNT_DEF,
    localparam int AW = tpbfs_pkg::idx_w(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tpbfs_front.sv =====
// request front end: accepts words and classifies them by opcode and address range
module tpbfs_front #(
    parameter int SMALL_COUNT = tpbfs_pkg::SMALL_COUNT_DEF,
    parameter int LARGE_COUNT = tpbfs_pkg::LARGE_COUNT_DEF,
    parameter int SMALL_BYTES = tpbfs_pkg::SMALL_BYTES_DEF,
    parameter int LARGE_BYTES = tpbfs_pkg::LARGE_BYTES_DEF
) (
    input  logic [tpbfs_pkg::ADDR_W-1:0] small_base,
    input  logic [tpbfs_pkg::ADDR_W-1:0] large_base,
    input  logic                         hold,
    tpbfs_req_if.sink                    req,
    output tpbfs_pkg::cmd_t              cmd,
    output logic                         push,
    input  logic                         full
);

    localparam int S_SPAN = SMALL_COUNT * SMALL_BYTES;
    localparam int L_SPAN = LARGE_COUNT * LARGE_BYTES;
    localparam int SPAN_W = $clog2((S_SPAN > L_SPAN ? S_SPAN : L_SPAN) + 1);
    localparam int END_W  = (SPAN_W > tpbfs_pkg::ADDR_W ? SPAN_W : tpbfs_pkg::ADDR_W) + 1;

    logic [END_W-1:0] s_start;
    logic [END_W-1:0] l_start;
    logic [END_W-1:0] s_end;
    logic [END_W-1:0] l_end;
    logic [END_W-1:0] addr_x;
    logic             in_small;
    logic             in_large;

    // range ends are formed without wrap
    assign s_start  = END_W'(small_base);
    assign l_start  = END_W'(large_base);
    assign s_end    = s_start + END_W'(S_SPAN);
    assign l_end    = l_start + END_W'(L_SPAN);
    assign addr_x   = END_W'(req.address);
    assign in_small = (addr_x >= s_start) && (addr_x < s_end);
    assign in_large = (addr_x >= l_start) && (addr_x < l_end);

    always_comb
    begin
        cmd.address = req.address;
        case (req.opcode)
            tpbfs_pkg::OP_ALLOC_SMALL: cmd.kind = tpbfs_pkg::CMD_ALLOC_S;
            tpbfs_pkg::OP_ALLOC_LARGE: cmd.kind = tpbfs_pkg::CMD_ALLOC_L;
            tpbfs_pkg::OP_FREE:
            begin
                // small pool wins on overlap
                if (in_small)
                begin
                    cmd.kind = tpbfs_pkg::CMD_FREE_S;
                end
                else if (in_large)
                begin
                    cmd.kind = tpbfs_pkg::CMD_FREE_L;
                end
                else
                begin
                    cmd.kind = tpbfs_pkg::CMD_INVALID;
                end
            end
            default: cmd.kind = tpbfs_pkg::CMD_REBUILD;
        endcase
    end

    assign req.ready = !full && !hold;
    assign push      = req.valid && req.ready;

endmodule

// ===== sv/tpbfs_queue.sv =====
// short command queue between the front end and the stack engine
module tpbfs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tpbfs_pkg::cmd_t push_cmd,
    output logic            full,
    input  logic            pop,
    output tpbfs_pkg::cmd_t pop_cmd,
    output logic            not_empty
);

    localparam int DEPTH = tpbfs_pkg::QUEUE_DEPTH;
    localparam int PW    = tpbfs_pkg::idx_w(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    tpbfs_pkg::cmd_t slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assign full      = (cnt_reg == CW'(DEPTH));
    assign not_empty = (cnt_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];

endmodule

// ===== sv/tpbfs_back.sv =====
// stack engine: pops, pushes and refills both free-address stacks, holds the result word
module tpbfs_back #(
    parameter int SMALL_COUNT = tpbfs_pkg::SMALL_COUNT_DEF,
    parameter int LARGE_COUNT = tpbfs_pkg::LARGE_COUNT_DEF,
    parameter int SMALL_BYTES = tpbfs_pkg::SMALL_BYTES_DEF,
    parameter int LARGE_BYTES = tpbfs_pkg::LARGE_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [tpbfs_pkg::ADDR_W-1:0] small_base,
    input  logic [tpbfs_pkg::ADDR_W-1:0] large_base,
    input  logic                         cmd_valid,
    input  tpbfs_pkg::cmd_t              cmd,
    output logic                         deq,
    output logic                         init_busy,
    tpbfs_rsp_if.source                  rsp
);

    localparam int AW     = tpbfs_pkg::ADDR_W;
    localparam int SCW    = $clog2(SMALL_COUNT + 1);
    localparam int LCW    = $clog2(LARGE_COUNT + 1);
    localparam int SAW    = tpbfs_pkg::idx_w(SMALL_COUNT);
    localparam int LAW    = tpbfs_pkg::idx_w(LARGE_COUNT);
    localparam int FILL_N = (SMALL_COUNT > LARGE_COUNT) ? SMALL_COUNT : LARGE_COUNT;
    localparam int FW     = $clog2(FILL_N + 1);

    localparam logic [1:0] S_RUN  = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_FILL = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [FW-1:0]                    fill_idx_reg, fill_idx_next;
    logic                             fill_out_reg, fill_out_next;
    logic [AW-1:0]                    small_acc_reg, small_acc_next;
    logic [AW-1:0]                    large_acc_reg, large_acc_next;
    logic [SCW-1:0]                   small_cnt_reg, small_cnt_next;
    logic [LCW-1:0]                   large_cnt_reg, large_cnt_next;
    logic [SCW-1:0]                   small_least_reg, small_least_next;
    logic [LCW-1:0]                   large_least_reg, large_least_next;
    logic                             out_valid_reg, out_valid_next;
    logic [AW-1:0]                    buf_reg, buf_next;
    logic [tpbfs_pkg::STATUS_W-1:0]   status_reg, status_next;
    logic [tpbfs_pkg::HIT_W-1:0]      hit_reg, hit_next;

    logic [SCW-1:0] small_top;
    logic [LCW-1:0] large_top;
    logic           fill_last;
    logic           small_we, large_we;
    logic [SAW-1:0] small_waddr;
    logic [LAW-1:0] large_waddr;
    logic [AW-1:0]  small_wdata, large_wdata;
    logic [AW-1:0]  small_rdata, large_rdata;

    assign small_top = small_cnt_reg - 1'b1;
    assign large_top = large_cnt_reg - 1'b1;
    assign fill_last = (fill_idx_reg == FW'(FILL_N - 1));
    assign deq       = cmd_valid && (state_reg == S_RUN) && (!out_valid_reg || rsp.ready);
    assign init_busy = (state_reg == S_FILL) && !fill_out_reg;

    tpbfs_ram #(.WIDTH(AW), .DEPTH(SMALL_COUNT)) u_small_ram (
        .clk   (clk),
        .we    (small_we),
        .waddr (small_waddr),
        .wdata (small_wdata),
        .raddr (small_top[SAW-1:0]),
        .rdata (small_rdata)
    );

    tpbfs_ram #(.WIDTH(AW), .DEPTH(LARGE_COUNT)) u_large_ram (
        .clk   (clk),
        .we    (large_we),
        .waddr (large_waddr),
        .wdata (large_wdata),
        .raddr (large_top[LAW-1:0]),
        .rdata (large_rdata)
    );

    always_comb
    begin
        state_next       = state_reg;
        fill_idx_next    = fill_idx_reg;
        fill_out_next    = fill_out_reg;
        small_acc_next   = small_acc_reg;
        large_acc_next   = large_acc_reg;
        small_cnt_next   = small_cnt_reg;
        large_cnt_next   = large_cnt_reg;
        small_least_next = small_least_reg;
        large_least_next = large_least_reg;
        out_valid_next   = out_valid_reg;
        buf_next         = buf_reg;
        status_next      = status_reg;
        hit_next         = hit_reg;
        small_we         = 1'b0;
        large_we         = 1'b0;
        small_waddr      = small_cnt_reg[SAW-1:0];
        large_waddr      = large_cnt_reg[LAW-1:0];
        small_wdata      = cmd.address;
        large_wdata      = cmd.address;

        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_RUN:
            begin
                if (deq)
                begin
                    buf_next       = '0;
                    status_next    = tpbfs_pkg::ST_OK;
                    hit_next       = tpbfs_pkg::HIT_NONE;
                    out_valid_next = 1'b1;
                    case (cmd.kind)
                        tpbfs_pkg::CMD_ALLOC_S:
                        begin
                            hit_next = tpbfs_pkg::HIT_SMALL;
                            if (small_cnt_reg != '0)
                            begin
                                small_cnt_next = small_top;
                                if (small_top < small_least_reg)
                                begin
                                    small_least_next = small_top;
                                end
                                // top entry arrives from the ram next cycle
                                out_valid_next = 1'b0;
                                state_next     = S_POP;
                            end
                            else
                            begin
                                status_next      = tpbfs_pkg::ST_EMPTY;
                                small_least_next = '0;
                            end
                        end
                        tpbfs_pkg::CMD_ALLOC_L:
                        begin
                            hit_next = tpbfs_pkg::HIT_LARGE;
                            if (large_cnt_reg != '0)
                            begin
                                large_cnt_next = large_top;
                                if (large_top < large_least_reg)
                                begin
                                    large_least_next = large_top;
                                end
                                out_valid_next = 1'b0;
                                state_next     = S_POP;
                            end
                            else
                            begin
                                status_next      = tpbfs_pkg::ST_EMPTY;
                                large_least_next = '0;
                            end
                        end
                        tpbfs_pkg::CMD_FREE_S:
                        begin
                            hit_next = tpbfs_pkg::HIT_SMALL;
                            if (small_cnt_reg >= SCW'(SMALL_COUNT))
                            begin
                                status_next = tpbfs_pkg::ST_FULL;
                            end
                            else
                            begin
                                small_we       = 1'b1;
                                small_cnt_next = small_cnt_reg + 1'b1;
                            end
                        end
                        tpbfs_pkg::CMD_FREE_L:
                        begin
                            hit_next = tpbfs_pkg::HIT_LARGE;
                            if (large_cnt_reg >= LCW'(LARGE_COUNT))
                            begin
                                status_next = tpbfs_pkg::ST_FULL;
                            end
                            else
                            begin
                                large_we       = 1'b1;
                                large_cnt_next = large_cnt_reg + 1'b1;
                            end
                        end
                        tpbfs_pkg::CMD_REBUILD:
                        begin
                            out_valid_next = 1'b0;
                            fill_idx_next  = '0;
                            fill_out_next  = 1'b1;
                            small_acc_next = small_base;
                            large_acc_next = large_base;
                            state_next     = S_FILL;
                        end
                        default:
                        begin
                            status_next = tpbfs_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                out_valid_next = 1'b1;
                buf_next       = (hit_reg == tpbfs_pkg::HIT_LARGE) ? large_rdata : small_rdata;
                state_next     = S_RUN;
            end
            S_FILL:
            begin
                // one entry of each stack per cycle while its index is in range, addresses by running sum
                small_we       = (fill_idx_reg < FW'(SMALL_COUNT));
                large_we       = (fill_idx_reg < FW'(LARGE_COUNT));
                small_waddr    = fill_idx_reg[SAW-1:0];
                large_waddr    = fill_idx_reg[LAW-1:0];
                small_wdata    = small_acc_reg;
                large_wdata    = large_acc_reg;
                small_acc_next = small_acc_reg + AW'(SMALL_BYTES);
                large_acc_next = large_acc_reg + AW'(LARGE_BYTES);
                fill_idx_next  = fill_idx_reg + 1'b1;
                if (fill_last)
                begin
                    small_cnt_next   = SCW'(SMALL_COUNT);
                    large_cnt_next   = LCW'(LARGE_COUNT);
                    small_least_next = SCW'(SMALL_COUNT);
                    large_least_next = LCW'(LARGE_COUNT);
                    state_next       = S_RUN;
                    if (fill_out_reg)
                    begin
                        out_valid_next = 1'b1;
                        buf_next       = '0;
                        status_next    = tpbfs_pkg::ST_OK;
                        hit_next       = tpbfs_pkg::HIT_NONE;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_FILL;
            fill_idx_reg    <= '0;
            fill_out_reg    <= 1'b0;
            small_acc_reg   <= tpbfs_pkg::SMALL_BASE_RST;
            large_acc_reg   <= tpbfs_pkg::LARGE_BASE_RST;
            small_cnt_reg   <= SCW'(SMALL_COUNT);
            large_cnt_reg   <= LCW'(LARGE_COUNT);
            small_least_reg <= SCW'(SMALL_COUNT);
            large_least_reg <= LCW'(LARGE_COUNT);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            fill_idx_reg    <= fill_idx_next;
            fill_out_reg    <= fill_out_next;
            small_acc_reg   <= small_acc_next;
            large_acc_reg   <= large_acc_next;
            small_cnt_reg   <= small_cnt_next;
            large_cnt_reg   <= large_cnt_next;
            small_least_reg <= small_least_next;
            large_least_reg <= large_least_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.buf_address     = buf_reg;
    assign rsp.status          = status_reg;
    assign rsp.pool_hit        = hit_reg;
    assign rsp.small_free      = tpbfs_pkg::SFREE_W'(small_cnt_reg);
    assign rsp.large_free      = tpbfs_pkg::LFREE_W'(large_cnt_reg);
    assign rsp.small_low_water = tpbfs_pkg::SFREE_W'(small_least_reg);
    assign rsp.large_low_water = tpbfs_pkg::LFREE_W'(large_least_reg);

    a_small_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        small_cnt_reg <= SCW'(SMALL_COUNT))
        else $error("small stack count above pool size");

    a_least_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (small_least_reg <= small_cnt_reg) && (large_least_reg <= large_cnt_reg))
        else $error("low-water mark above free count");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> !out_valid_reg)
        else $error("pop result would overwrite a pending word");

    a_fill_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FILL) && fill_last) |=>
            ((small_cnt_reg == SCW'(SMALL_COUNT)) && (large_cnt_reg == LCW'(LARGE_COUNT))
             && (state_reg == S_RUN)))
        else $error("refill did not restore full stacks");

endmodule

// ===== sv/two_pool_buffer_free_stack_core.sv =====
// Two-pool buffer allocator: a small and a large pool, each a stack of free buffer
// addresses in its own ram. A free is done in the stack engine's run state, an allocation
// also passes its pop state (the top entry comes through the ram's registered read port;
// not when the pool is empty), and a rebuild rewrites both rams one entry per cycle.
// Requests are classified on entry and wait in a two-word queue, so req keeps accepting
// while a result word waits on rsp, until that queue is full. After reset the same
// refill pass runs with req.ready low; configuration writes are taken throughout. Base
// registers take effect at the next rebuild for the stack contents and at once for the
// address ranges of a free.
module two_pool_buffer_free_stack_core #(
    parameter int SMALL_COUNT = tpbfs_pkg::SMALL_COUNT_DEF,
    parameter int LARGE_COUNT = tpbfs_pkg::LARGE_COUNT_DEF,
    parameter int SMALL_BYTES = tpbfs_pkg::SMALL_BYTES_DEF,
    parameter int LARGE_BYTES = tpbfs_pkg::LARGE_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tpbfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tpbfs_pkg::ADDR_W-1:0]    cfg_data,
    tpbfs_req_if.sink                       req,
    tpbfs_rsp_if.source                     rsp
);

    logic [tpbfs_pkg::ADDR_W-1:0] small_base_reg;
    logic [tpbfs_pkg::ADDR_W-1:0] large_base_reg;
    tpbfs_pkg::cmd_t              front_cmd;
    tpbfs_pkg::cmd_t              queue_cmd;
    logic                         push;
    logic                         full;
    logic                         deq;
    logic                         queue_valid;
    logic                         init_busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_base_reg <= tpbfs_pkg::SMALL_BASE_RST;
            large_base_reg <= tpbfs_pkg::LARGE_BASE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpbfs_pkg::CFG_SMALL_BASE: small_base_reg <= cfg_data;
                tpbfs_pkg::CFG_LARGE_BASE: large_base_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    tpbfs_front #(
        .SMALL_COUNT (SMALL_COUNT),
        .LARGE_COUNT (LARGE_COUNT),
        .SMALL_BYTES (SMALL_BYTES),
        .LARGE_BYTES (LARGE_BYTES)
    ) u_front (
        .small_base (small_base_reg),
        .large_base (large_base_reg),
        .hold       (init_busy),
        .req        (req),
        .cmd        (front_cmd),
        .push       (push),
        .full       (full)
    );

    tpbfs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (front_cmd),
        .full      (full),
        .pop       (deq),
        .pop_cmd   (queue_cmd),
        .not_empty (queue_valid)
    );

    tpbfs_back #(
        .SMALL_COUNT (SMALL_COUNT),
        .LARGE_COUNT (LARGE_COUNT),
        .SMALL_BYTES (SMALL_BYTES),
        .LARGE_BYTES (LARGE_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .small_base (small_base_reg),
        .large_base (large_base_reg),
        .cmd_valid  (queue_valid),
        .cmd        (queue_cmd),
        .deq        (deq),
        .init_busy  (init_busy),
        .rsp        (rsp)
    );

endmodule
